[rtl/core/ssn_pkg.sv]
// ----------------------------------------------------------------------------
// ssn_pkg: shared types and constants for the symbol spectrum normalizer
// Holds the item structs, the command and status structs that join the
// controller and datapath, and the fixed field widths.
// ----------------------------------------------------------------------------
package ssn_pkg;

  localparam int SYM_W      = 6;
  localparam int CNT_W      = 16;
  localparam int SQ_W       = 2 * CNT_W;
  localparam int SUM_W      = 38;  // 64 bins of squared 16-bit counts
  localparam int Q_W        = 31;  // quotient of c*c*2^30/S is at most 2^30
  localparam int RT_W       = 32;
  localparam int STEP_W     = 5;
  localparam int DIV_STEPS  = 30;
  localparam int SQRT_STEPS = 16;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] bin_index;
    logic [CNT_W-1:0] bin_value;
    logic             last_bin;
  } out_item_t;

  typedef struct packed {
    logic             accept;
    logic             sum_clr;
    logic             sum_rd;
    logic             load;
    logic             div_init;
    logic             div_step;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             emit;
    logic             emit_raw;
    logic             emit_norm;
    logic             clear;
    logic             last;
    logic [SYM_W-1:0] addr;
  } ssn_cmd_t;

  typedef struct packed {
    logic sum_zero;
  } ssn_stat_t;

endpackage

[rtl/core/ssn_ram.sv]
// ----------------------------------------------------------------------------
// ssn_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/ssn_datapath.sv]
// ----------------------------------------------------------------------------
// ssn_datapath: bin store, sum of squares, divider, square root, output
// Counts symbols with read-modify-write on the bin RAM, then computes the
// normalized value of each bin with a bit-serial divider and square root.
// ----------------------------------------------------------------------------
module ssn_datapath #(
  parameter int NUM_BINS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ssn_pkg::in_item_t  in_item,
  input  ssn_pkg::ssn_cmd_t  cmd,
  output ssn_pkg::ssn_stat_t stat,
  output logic               out_strobe,
  output ssn_pkg::out_item_t out_item
);
  import ssn_pkg::*;

  localparam int AW = $clog2(NUM_BINS);
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic [AW-1:0]     raddr, rd_addr_r;
  logic [CNT_W-1:0]  rdata, count_rd, old_cnt, new_cnt;
  logic              in_range;
  logic              s1_vld_r;
  logic [AW-1:0]     s1_addr_r;
  logic              wr_vld_r;
  logic [AW-1:0]     wr_addr_r;
  logic [CNT_W-1:0]  wr_val_r;
  logic [NUM_BINS-1:0] vld_r;
  logic              rd_sum_r, sq_sum_r;
  logic [SQ_W-1:0]   sq_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SUM_W:0]    rem_r, rem_sh, sq_ext;
  logic [Q_W-1:0]    q_r;
  logic [RT_W-1:0]   v_r, res_r, bit_r, trial;
  logic              out_strobe_r;
  out_item_t         out_r;

  assign in_range = {1'b0, in_item.symbol} < (SYM_W+1)'(NUM_BINS);
  assign raddr    = cmd.accept ? in_item.symbol[AW-1:0] : cmd.addr[AW-1:0];
  assign count_rd = vld_r[rd_addr_r] ? rdata : '0;

  // A bin written on the edge of its own read still shows the old word.
  assign old_cnt = (wr_vld_r && (wr_addr_r == s1_addr_r)) ? wr_val_r : count_rd;
  assign new_cnt = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + CNT_W'(1);

  ssn_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BINS)) u_bins (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_addr_r),
    .wdata (new_cnt),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sq_ext = (SUM_W+1)'(sq_r);
  assign rem_sh = {rem_r[SUM_W-1:0], 1'b0};
  assign trial  = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      wr_vld_r     <= 1'b0;
      vld_r        <= '0;
      rd_sum_r     <= 1'b0;
      sq_sum_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_vld_r     <= cmd.accept && in_range;
      wr_vld_r     <= s1_vld_r;
      rd_sum_r     <= cmd.sum_rd;
      sq_sum_r     <= rd_sum_r;
      out_strobe_r <= cmd.emit;
      if (cmd.clear) begin
        vld_r <= '0;
      end else if (s1_vld_r) begin
        vld_r[s1_addr_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r <= raddr;
    s1_addr_r <= in_item.symbol[AW-1:0];
    wr_addr_r <= s1_addr_r;
    wr_val_r  <= new_cnt;
    if (rd_sum_r || cmd.load) begin
      sq_r <= SQ_W'(count_rd) * SQ_W'(count_rd);
    end
    if (cmd.sum_clr) begin
      sum_r <= '0;
    end else if (sq_sum_r) begin
      sum_r <= sum_r + SUM_W'(sq_r);
    end
    if (cmd.load) begin
      cnt_r <= count_rd;
    end
    if (cmd.div_init) begin
      if (sq_ext >= {1'b0, sum_r}) begin
        rem_r <= sq_ext - {1'b0, sum_r};
        q_r   <= Q_W'(1);
      end else begin
        rem_r <= sq_ext;
        q_r   <= '0;
      end
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, sum_r}) begin
        rem_r <= rem_sh - {1'b0, sum_r};
        q_r   <= {q_r[Q_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        q_r   <= {q_r[Q_W-2:0], 1'b0};
      end
    end
    if (cmd.sqrt_init) begin
      v_r   <= RT_W'(q_r);
      res_r <= '0;
      bit_r <= RT_W'(1) << (RT_W - 2);
    end else if (cmd.sqrt_step) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.emit) begin
      out_r.bin_index <= cmd.addr;
      out_r.last_bin  <= cmd.last;
      if (cmd.emit_raw) begin
        out_r.bin_value <= cnt_r;
      end else if (cmd.emit_norm) begin
        out_r.bin_value <= res_r[CNT_W-1:0];
      end else begin
        out_r.bin_value <= '0;
      end
    end
  end

  assign stat.sum_zero = (sum_r == '0);
  assign out_strobe    = out_strobe_r;
  assign out_item      = out_r;

endmodule

[rtl/core/ssn_ctrl.sv]
// ----------------------------------------------------------------------------
// ssn_ctrl: sequencer for counting, the sum sweep and per-bin emission
// Holds the normalize register and steps the datapath through each pass.
// ----------------------------------------------------------------------------
module ssn_ctrl #(
  parameter int NUM_BINS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ssn_pkg::in_item_t  in_item,
  output logic               busy,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  ssn_pkg::ssn_stat_t stat,
  output ssn_pkg::ssn_cmd_t  cmd
);
  import ssn_pkg::*;

  localparam logic [SYM_W-1:0] LAST_K = SYM_W'(NUM_BINS - 1);

  typedef enum logic [11:0] {
    ST_IDLE  = 12'b0000_0000_0001,
    ST_DRAIN = 12'b0000_0000_0010,
    ST_SUM   = 12'b0000_0000_0100,
    ST_SUMW  = 12'b0000_0000_1000,
    ST_RD    = 12'b0000_0001_0000,
    ST_LOAD  = 12'b0000_0010_0000,
    ST_DINIT = 12'b0000_0100_0000,
    ST_DIV   = 12'b0000_1000_0000,
    ST_SINIT = 12'b0001_0000_0000,
    ST_SQRT  = 12'b0010_0000_0000,
    ST_EMIT  = 12'b0100_0000_0000,
    ST_CLEAR = 12'b1000_0000_0000
  } state_t;

  state_t            state_r, state_nxt;
  logic [SYM_W-1:0]  k_r, k_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              normalize_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      k_r         <= '0;
      step_r      <= '0;
      normalize_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      step_r  <= step_nxt;
      if (cfg_we) begin
        normalize_r <= cfg_wdata;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    step_nxt      = step_r;
    cmd           = '0;
    cmd.addr      = k_r;
    cmd.last      = (k_r == LAST_K);
    cmd.emit_raw  = !normalize_r;
    cmd.emit_norm = normalize_r && !stat.sum_zero;
    case (state_r)
      ST_IDLE: begin
        cmd.accept = start;
        if (start && in_item.end_of_string) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cmd.sum_clr = 1'b1;
        k_nxt       = '0;
        state_nxt   = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_rd = 1'b1;
        if (k_r == LAST_K) begin
          k_nxt     = '0;
          step_nxt  = '0;
          state_nxt = ST_SUMW;
        end else begin
          k_nxt = k_r + SYM_W'(1);
        end
      end
      ST_SUMW: begin
        // This wait lets the last square pass the squaring register into the accumulator.
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
        if (normalize_r && !stat.sum_zero) begin
          state_nxt = ST_DINIT;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        step_nxt     = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_SINIT;
        end
      end
      ST_SINIT: begin
        cmd.sqrt_init = 1'b1;
        step_nxt      = '0;
        state_nxt     = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_nxt      = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (k_r == LAST_K) begin
          state_nxt = ST_CLEAR;
        end else begin
          k_nxt     = k_r + SYM_W'(1);
          state_nxt = ST_RD;
        end
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

[rtl/core/symbol_spectrum_normalizer.sv]
// ----------------------------------------------------------------------------
// symbol_spectrum_normalizer: per-string symbol histogram with L2 scaling
// Counts symbols into NUM_BINS saturating bins and emits the spectrum at the
// end of each string, raw or divided by its L2 norm in Q1.15.
// ----------------------------------------------------------------------------
// Usage:
//   An item (in_item) is taken on a clock edge with start high and busy low.
//   Ordinary symbols are taken one per cycle; counting is a read-modify-write
//   on the bin RAM with forwarding between back-to-back items.
//   An item with end_of_string set raises busy for the whole emission pass:
//   a drain state, the sum-of-squares sweep over all bins, then per bin a read
//   and a load state, for normalized output with a nonzero sum the 30-step
//   divider and the 16-step square root, then the emit state, and a clear
//   state at the end.
//   Each result appears on out_item for one cycle with out_strobe high, in
//   bin order; last_bin marks the final bin. The receiver cannot stall.
//   cfg_we writes the normalize bit; write it only while the block is idle.
//   Reset (rst_n low, synchronous) empties the store and clears normalize.
// ----------------------------------------------------------------------------
module symbol_spectrum_normalizer #(
  parameter int NUM_BINS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ssn_pkg::in_item_t  in_item,
  output logic               out_strobe,
  output ssn_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);
  import ssn_pkg::*;

  ssn_cmd_t  cmd;
  ssn_stat_t stat;

  ssn_ctrl #(.NUM_BINS(NUM_BINS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_item   (in_item),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .cmd       (cmd)
  );

  ssn_datapath #(.NUM_BINS(NUM_BINS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule
